FILE: design/rba_pkg.sv
// Shared types and codes for the region bump allocator.
package rba_pkg;

  localparam int ADDR_W  = 32;
  localparam int PAGES_W = 21;
  localparam logic [PAGES_W-1:0] PAGES_MAX = 21'h1F_FFFF;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_ZERO_SIZE = 2'd3;

  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] byte_count;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  region_address;
    logic [PAGES_W-1:0] page_count;
    logic [1:0]         status;
    logic               legitimate;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [PAGES_W-1:0] pages;
  } region_t;

endpackage

FILE: design/rba_region_ram.sv
// Region table memory: one write port, one registered read port.
module rba_region_ram #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  rba_pkg::region_t    wdata,
  input  logic [IDX_W-1:0]    raddr,
  output rba_pkg::region_t    rdata
);

  rba_pkg::region_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/region_bump_allocator_top.sv
// Region bump allocator top level: command sequencer around the region table.
//
// A command is taken when start is high and busy is low; its single result
// shows on result for one cycle with done high and cannot be held off.
// Check, unused codes, a zero-size or full-table allocate, a release on an
// empty table and the first allocate into an empty table finish straight
// from idle, with their result in the cycle after they are taken. Any other
// allocate does one region table read of the last live entry, then the
// write of the new one. A release reads the live entries one per cycle
// through the table's single read port until it finds the start, then
// moves each later entry down one place, one per cycle. A new command is
// taken in the cycle its predecessor's result shows. PAGE_BYTES must be a
// power of two. The region table needs no clearing after reset.
module region_bump_allocator_top #(
  parameter int MAX_REGION_COUNT = 16,
  parameter int PAGE_BYTES       = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rba_pkg::req_t request,
  output logic          done,
  output rba_pkg::rsp_t result,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int IDX_W = (MAX_REGION_COUNT > 1) ? $clog2(MAX_REGION_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_REGION_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REGION_COUNT);
  localparam logic [32:0] ROUND_ADD = 33'(PAGE_BYTES - 1);
  localparam int          PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [31:0] PAGE_MUL  = 32'(PAGE_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ALLOC  = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_SHIFT  = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     live, live_next;
  logic [IDX_W-1:0]     idx, idx_next;
  rba_pkg::req_t        req, req_next;
  logic [20:0]          want_pages, want_pages_next;
  logic [20:0]          hit_pages, hit_pages_next;
  logic [31:0]          pool_base, pool_size;
  logic                 done_next;
  rba_pkg::rsp_t        result_next;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  rba_pkg::region_t     mem_wdata, mem_rdata;

  logic [32:0]          bytes_round;
  logic [32:0]          pages_raw;
  logic [20:0]          pages_sat;
  logic [32:0]          pool_end;
  logic                 in_pool;
  logic [31:0]          next_start;
  logic [CNT_W-1:0]     idx_inc;

  rba_region_ram #(
    .DEPTH(MAX_REGION_COUNT),
    .IDX_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy        = (state != ST_IDLE);
  assign bytes_round = {1'b0, request.byte_count} + ROUND_ADD;
  assign pages_raw   = bytes_round >> PAGE_SHIFT;
  assign pages_sat   = (pages_raw > {12'd0, rba_pkg::PAGES_MAX}) ? rba_pkg::PAGES_MAX
                                                                 : pages_raw[20:0];
  assign pool_end    = {1'b0, pool_base} + {1'b0, pool_size};
  assign in_pool     = (request.address >= pool_base) && ({1'b0, request.address} < pool_end);
  assign next_start  = mem_rdata.start + (32'(mem_rdata.pages) << PAGE_SHIFT);
  assign idx_inc     = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    state_next        = state;
    live_next         = live;
    idx_next          = idx;
    req_next          = req;
    want_pages_next   = want_pages;
    hit_pages_next    = hit_pages;
    done_next         = 1'b0;
    result_next       = '0;
    mem_we            = 1'b0;
    mem_waddr         = idx;
    mem_wdata         = mem_rdata;
    mem_raddr         = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          req_next        = request;
          want_pages_next = pages_sat;
          case (request.command)
            rba_pkg::CMD_ALLOC: begin
              if (request.byte_count == 32'd0) begin
                done_next          = 1'b1;
                result_next.status = rba_pkg::STATUS_ZERO_SIZE;
              end else if (live == CNT_FULL) begin
                done_next          = 1'b1;
                result_next.status = rba_pkg::STATUS_FULL;
              end else if (live == '0) begin
                mem_we                     = 1'b1;
                mem_waddr                  = '0;
                mem_wdata.start            = pool_base + PAGE_MUL;
                mem_wdata.pages            = pages_sat;
                live_next                  = live + CNT_W'(1);
                done_next                  = 1'b1;
                result_next.region_address = pool_base + PAGE_MUL;
                result_next.page_count     = pages_sat;
                result_next.status         = rba_pkg::STATUS_OK;
              end else begin
                mem_raddr  = IDX_W'(live - CNT_W'(1));
                state_next = ST_ALLOC;
              end
            end
            rba_pkg::CMD_RELEASE: begin
              if (live == '0) begin
                done_next                  = 1'b1;
                result_next.region_address = request.address;
                result_next.status         = rba_pkg::STATUS_NOT_FOUND;
              end else begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = ST_SEARCH;
              end
            end
            rba_pkg::CMD_CHECK: begin
              done_next              = 1'b1;
              result_next.legitimate = in_pool;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        mem_we                     = 1'b1;
        mem_waddr                  = IDX_W'(live);
        mem_wdata.start            = next_start;
        mem_wdata.pages            = want_pages;
        live_next                  = live + CNT_W'(1);
        done_next                  = 1'b1;
        result_next.region_address = next_start;
        result_next.page_count     = want_pages;
        result_next.status         = rba_pkg::STATUS_OK;
        state_next                 = ST_IDLE;
      end
      ST_SEARCH: begin
        if (mem_rdata.start == req.address) begin
          hit_pages_next = mem_rdata.pages;
          mem_raddr      = idx + IDX_W'(1);
          state_next     = ST_SHIFT;
        end else if (idx_inc >= live) begin
          done_next                  = 1'b1;
          result_next.region_address = req.address;
          result_next.status         = rba_pkg::STATUS_NOT_FOUND;
          state_next                 = ST_IDLE;
        end else begin
          idx_next  = idx + IDX_W'(1);
          mem_raddr = idx + IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        if (idx_inc < live) begin
          mem_we    = 1'b1;
          mem_waddr = idx;
          mem_wdata = mem_rdata;
          idx_next  = idx + IDX_W'(1);
          mem_raddr = idx + IDX_W'(2);
        end else begin
          live_next                  = live - CNT_W'(1);
          done_next                  = 1'b1;
          result_next.region_address = req.address;
          result_next.page_count     = hit_pages;
          result_next.status         = rba_pkg::STATUS_OK;
          state_next                 = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      live      <= '0;
      done      <= 1'b0;
      pool_base <= '0;
      pool_size <= '0;
    end else begin
      state <= state_next;
      live  <= live_next;
      done  <= done_next;
      if (cfg_write) begin
        unique case (cfg_index)
          rba_pkg::CFG_POOL_BASE: pool_base <= cfg_data;
          rba_pkg::CFG_POOL_SIZE: pool_size <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    req        <= req_next;
    want_pages <= want_pages_next;
    hit_pages  <= hit_pages_next;
    result     <= result_next;
  end

endmodule

FILE: design/rba_checker.sv
// Port-level checker for the region bump allocator, bound to the top level.
module rba_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input rba_pkg::rsp_t result
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !done)
    else $error("result strobe without a transaction");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted transaction neither finished nor in progress");

  a_busy_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted transaction");

  a_check_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.legitimate) |->
      (result.status == rba_pkg::STATUS_OK && result.page_count == '0 &&
       result.region_address == '0))
    else $error("check result carries region fields");

endmodule

bind region_bump_allocator_top rba_checker u_rba_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
